FILE: design/multi_tone_sine_synthesizer_macros.svh
// ----------------------------------------------------------------------------
// multi-tone sine synthesizer assertion macros
// shared property wrappers on i_clk, held off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef MULTI_TONE_SINE_SYNTHESIZER_MACROS_SVH
`define MULTI_TONE_SINE_SYNTHESIZER_MACROS_SVH

// same-cycle implication
`define MTSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mtss assertion failed");

// next-cycle implication
`define MTSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mtss assertion failed");

`endif

FILE: design/mtss_pkg.sv
// ----------------------------------------------------------------------------
// mtss_pkg
// sizes, tone entry layout and the quarter-wave sine table builder
// ----------------------------------------------------------------------------
package mtss_pkg;

    localparam int TONE_SLOTS      = 64;
    localparam int SINE_TABLE_BITS = 10;
    localparam int ROM_SIZE        = 1 << SINE_TABLE_BITS;
    localparam int ROM_IDX_W       = SINE_TABLE_BITS + 1;
    localparam int ADDR_W          = (TONE_SLOTS > 1) ? $clog2(TONE_SLOTS) : 1;
    localparam int CNT_W           = $clog2(TONE_SLOTS + 1);

    localparam int COUNT_W  = 7;
    localparam int INDEX_W  = 6;
    localparam int STEP_W   = 32;
    localparam int GAIN_W   = 16;
    localparam int SINE_W   = 16;
    localparam int PROD_W   = GAIN_W + SINE_W;
    localparam int FRAC_SH  = 12;
    localparam int TERM_W   = PROD_W - FRAC_SH;
    localparam int SAMPLE_W = 26;
    localparam int ACC_W    = (TERM_W + 1 + ADDR_W > SAMPLE_W + 1) ?
                              (TERM_W + 1 + ADDR_W) : (SAMPLE_W + 1);

    localparam logic signed [ACC_W-1:0] ACC_SAT_MAX =
        ACC_W'((longint'(1) <<< (SAMPLE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] ACC_SAT_MIN = -ACC_SAT_MAX - 1;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156, 64'd210, 64'd272};

    // input word operation codes
    typedef enum logic {OP_TICK = 1'b0, OP_WRITE = 1'b1} t_op;

    typedef struct packed {
        logic        [STEP_W-1:0] step;
        logic signed [GAIN_W-1:0] gain;
        logic        [STEP_W-1:0] phase;
    } t_tone_entry;

    localparam int ENTRY_W = $bits(t_tone_entry);

    typedef logic [SINE_W-1:0] t_rom [0:ROM_SIZE];

    function automatic t_rom build_sine_rom();
        t_rom        rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] v;
        longint      sum;
        for (int k = 0; k <= ROM_SIZE; k++) begin
            if (k == ROM_SIZE) begin
                rom[k] = SINE_W'(32767);
            end else begin
                x    = (64'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS;
                x2   = (x * x) >> 30;
                term = x;
                sum  = longint'(x);
                for (int n = 1; n <= 8; n++) begin
                    term = (term * x2) >> 30;
                    term = term / TAYLOR_DIV[n-1];
                    if ((n & 1) != 0) begin
                        sum = sum - longint'(term);
                    end else begin
                        sum = sum + longint'(term);
                    end
                end
                if (sum < 0) begin
                    sum = 0;
                end
                v = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
                if (v > 64'd32767) begin
                    v = 64'd32767;
                end
                rom[k] = SINE_W'(v);
            end
        end
        return rom;
    endfunction

endpackage

FILE: design/mtss_if.sv
// ----------------------------------------------------------------------------
// mtss channel interfaces
// valid/ready channels for config, input words and output samples
// ----------------------------------------------------------------------------
interface mtss_cfg_if;
    import mtss_pkg::*;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] tone_count;
    modport source (output valid, output tone_count, input ready);
    modport sink   (input valid, input tone_count, output ready);
endinterface

interface mtss_in_if;
    import mtss_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic        [INDEX_W-1:0] tone_index;
    logic        [STEP_W-1:0]  phase_step;
    logic signed [GAIN_W-1:0]  tone_gain;
    modport source (output valid, output operation, output tone_index,
                    output phase_step, output tone_gain, input ready);
    modport sink   (input valid, input operation, input tone_index,
                    input phase_step, input tone_gain, output ready);
endinterface

interface mtss_out_if;
    import mtss_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

FILE: design/mtss_ram.sv
// ----------------------------------------------------------------------------
// mtss_ram
// generic single-clock ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mtss_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 80
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                          i_wr_data,
    input  logic                                      i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                          o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

FILE: design/mtss_sine_rom.sv
// ----------------------------------------------------------------------------
// mtss_sine_rom
// quarter-wave sine lookup with registered table read and quadrant sign
// ----------------------------------------------------------------------------
module mtss_sine_rom (
    input  logic                                 i_clk,
    input  logic [mtss_pkg::STEP_W-1:0]          i_phase,
    output logic signed [mtss_pkg::SINE_W-1:0]   o_sine
);
    import mtss_pkg::*;

    localparam t_rom SINE_ROM = build_sine_rom();

    logic [SINE_TABLE_BITS-1:0] w_fine;
    logic [ROM_IDX_W-1:0]       w_idx;
    logic [SINE_W-1:0]          r_mag;
    logic                       r_neg;

    assign w_fine = i_phase[STEP_W-3 -: SINE_TABLE_BITS];
    assign w_idx  = i_phase[STEP_W-2] ? (ROM_IDX_W'(ROM_SIZE) - {1'b0, w_fine})
                                      : {1'b0, w_fine};

    always_ff @(posedge i_clk) begin
        r_mag <= SINE_ROM[w_idx];
        r_neg <= i_phase[STEP_W-1];
    end

    assign o_sine = r_neg ? -$signed(r_mag) : $signed(r_mag);
endmodule

FILE: design/multi_tone_sine_synthesizer.sv
// ----------------------------------------------------------------------------
// multi_tone_sine_synthesizer
// additive oscillator: tone entries in one ram, read-modify-write per tone
// ----------------------------------------------------------------------------
// write word: written to the tone ram as it is accepted, ready stays high
// tick word: tone_count clamped to TONE_SLOTS, saturated tone sum sent as the sample (0 tones: 0)
// one tone per cycle, paced by the single read port of the tone ram
// next word is taken once the sample sits in the output register
// reset clears control, tone_count and output valid; tone entries stay undefined
module multi_tone_sine_synthesizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mtss_cfg_if.sink    i_cfg,
    mtss_in_if.sink     i_in,
    mtss_out_if.source  o_out
);
    import mtss_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                r_state, n_state;
    logic [CNT_W-1:0]          r_tone, n_tone;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [COUNT_W-1:0]        r_tone_count;
    logic                      r_v1, r_v2, r_v3;
    logic [ADDR_W-1:0]         r_a1;
    logic signed [GAIN_W-1:0]  r_gain2;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc, n_acc;
    logic                      r_out_valid, n_out_valid;
    logic signed [SAMPLE_W-1:0] r_sample, n_sample;

    logic                      w_in_fire;
    logic                      w_idx_ok;
    logic [CNT_W-1:0]          w_count;
    logic                      w_rd_en;
    logic [ADDR_W-1:0]         w_rd_addr;
    logic                      w_wr_en;
    logic [ADDR_W-1:0]         w_wr_addr;
    t_tone_entry               w_wr_entry;
    t_tone_entry               w_rd_entry;
    logic [ENTRY_W-1:0]        w_rd_data;
    logic signed [SINE_W-1:0]  w_sine;
    logic signed [TERM_W-1:0]  w_term;
    logic signed [SAMPLE_W-1:0] w_sat;
    logic                      w_out_free;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_in_fire   = i_in.valid && i_in.ready;
    assign w_idx_ok    = (32'(i_in.tone_index) < TONE_SLOTS);
    assign w_count     = (32'(r_tone_count) > TONE_SLOTS) ? CNT_W'(TONE_SLOTS)
                                                          : CNT_W'(r_tone_count);

    assign w_rd_en   = (r_state == S_ISSUE);
    assign w_rd_addr = r_tone[ADDR_W-1:0];
    assign w_rd_entry = t_tone_entry'(w_rd_data);

    always_comb begin
        w_wr_entry = '0;
        if (r_v1) begin
            w_wr_en          = 1'b1;
            w_wr_addr        = r_a1;
            w_wr_entry.step  = w_rd_entry.step;
            w_wr_entry.gain  = w_rd_entry.gain;
            w_wr_entry.phase = w_rd_entry.phase + w_rd_entry.step;
        end else begin
            w_wr_en          = w_in_fire && (i_in.operation == OP_WRITE) && w_idx_ok;
            w_wr_addr        = ADDR_W'(i_in.tone_index);
            w_wr_entry.step  = i_in.phase_step;
            w_wr_entry.gain  = i_in.tone_gain;
            w_wr_entry.phase = '0;
        end
    end

    mtss_ram #(
        .DEPTH (TONE_SLOTS),
        .WIDTH (ENTRY_W)
    ) u_tone_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (ENTRY_W'(w_wr_entry)),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    mtss_sine_rom u_sine_rom (
        .i_clk   (i_clk),
        .i_phase (w_rd_entry.phase),
        .o_sine  (w_sine)
    );

    assign w_term = TERM_W'(r_prod >>> FRAC_SH);
    assign w_sat  = (r_acc > ACC_SAT_MAX) ? SAMPLE_W'(ACC_SAT_MAX) :
                    (r_acc < ACC_SAT_MIN) ? SAMPLE_W'(ACC_SAT_MIN) : SAMPLE_W'(r_acc);
    assign w_out_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state     = r_state;
        n_tone      = r_tone;
        n_count     = r_count;
        n_acc       = r_acc;
        n_sample    = r_sample;
        n_out_valid = r_out_valid && !o_out.ready;
        if (r_v3) begin
            n_acc = r_acc + {{(ACC_W-TERM_W){w_term[TERM_W-1]}}, w_term};
        end
        case (r_state)
            S_IDLE: begin
                if (w_in_fire && (i_in.operation == OP_TICK)) begin
                    n_acc   = '0;
                    n_tone  = '0;
                    n_count = w_count;
                    n_state = (w_count == '0) ? S_DONE : S_ISSUE;
                end
            end
            S_ISSUE: begin
                n_tone = r_tone + 1'b1;
                if (CNT_W'(r_tone + 1'b1) == r_count) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!(r_v1 || r_v2 || r_v3)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_sample    = w_sat;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tone       <= '0;
            r_count      <= '0;
            r_tone_count <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tone      <= n_tone;
            r_count     <= n_count;
            r_v1        <= w_rd_en;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_tone_count <= i_cfg.tone_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a1     <= w_rd_addr;
        r_gain2  <= w_rd_entry.gain;
        r_prod   <= r_gain2 * w_sine;
        r_acc    <= n_acc;
        r_sample <= n_sample;
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.sample = r_sample;

`include "multi_tone_sine_synthesizer_macros.svh"

    `MTSS_ASSERT_NOW(a_idle_pipe_empty, r_state == S_IDLE, !(r_v1 || r_v2 || r_v3))
    `MTSS_ASSERT_NOW(a_issue_in_range, r_state == S_ISSUE, r_tone < r_count)
    `MTSS_ASSERT_NOW(a_writeback_addr, r_v1, r_a1 == $past(w_rd_addr))
    `MTSS_ASSERT_NEXT(a_done_emits, (r_state == S_DONE) && w_out_free, o_out.valid)

endmodule
